// ----- rtl/rapm_pkg.sv -----
// ============================================================================
// rapm_pkg
// Shared types and constants for the rotate-add generator with modulo draw.
// ============================================================================
package rapm_pkg;

   localparam int WORD_W      = 32;
   localparam int SEED_ROUNDS = 32;
   localparam int REM_W       = WORD_W + 1;
   localparam int CNT_W       = ($clog2(SEED_ROUNDS) > $clog2(WORD_W)) ?
                                $clog2(SEED_ROUNDS) : $clog2(WORD_W);

   localparam logic [WORD_W-1:0] RESET_HIGH     = 32'hDEAD_BEEF;
   localparam logic [WORD_W-1:0] RESET_LOW      = 32'h0123_4567;
   localparam logic [WORD_W-1:0] ZERO_SEED_HIGH = 32'h6000_9755;
   localparam logic [WORD_W-1:0] ZERO_SEED_T    = 32'hDEAD_BEEF;
   localparam logic [WORD_W-1:0] SEED_XOR_MASK  = 32'hBEAD_29BA;
   localparam int                ROT_AMOUNT     = 16;

   typedef enum logic {
      CMD_SEED = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_ADVANCE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v);
      return {v[WORD_W-ROT_AMOUNT-1:0], v[WORD_W-1:WORD_W-ROT_AMOUNT]};
   endfunction

endpackage

// ----- rtl/rapm_cell.sv -----
// ============================================================================
// rapm_cell
// One bit of the partial remainder and divisor, with its own subtract slice.
// ============================================================================
module rapm_cell (
   input  logic                    clock,
   input  rapm_pkg::cell_ctrl_type ctrl,
   input  logic                    dvs_bit,
   input  logic                    shift_in,
   input  logic                    borrow_in,
   input  logic                    restore,
   output logic                    borrow_out,
   output logic                    rem_bit
);

   logic rem_bit_ff, rem_bit_in;
   logic dvs_bit_ff, dvs_bit_in;
   logic diff;

   assign diff       = shift_in ^ dvs_bit_ff ^ borrow_in;
   assign borrow_out = (~shift_in & dvs_bit_ff) | (~(shift_in ^ dvs_bit_ff) & borrow_in);
   assign rem_bit    = rem_bit_ff;

   always_comb begin
      rem_bit_in = rem_bit_ff;
      dvs_bit_in = dvs_bit_ff;
      if (ctrl.load) begin
         rem_bit_in = 1'b0;
         dvs_bit_in = dvs_bit;
      end else if (ctrl.step) begin
         rem_bit_in = restore ? shift_in : diff;
      end
   end

   always_ff @(posedge clock) begin
      rem_bit_ff <= rem_bit_in;
      dvs_bit_ff <= dvs_bit_in;
   end

endmodule

// ----- rtl/rotate_add_prng_modulo.sv -----
// ============================================================================
// rotate_add_prng_modulo
// Two-word rotate-add generator: reseed with round loop, draw modulo a range
// through a row of restoring-division bit cells.
// ============================================================================
//  channel  ports                                     direction
//  req      req_valid req_stall req_cmd req_operand   in
//  rsp      rsp_valid rsp_stall rsp_random_value      out
//
//  Reseed: SEED_ROUNDS rounds in the seed state after acceptance, then the
//  done state loads the result register.
//  Draw: one advance step, then one quotient bit per cycle while dividing,
//  then done; a zero range goes straight to done. Remainder row: 33 cells.
//  One word at a time; req_stall is high from acceptance until the result
//  enters the output register, which a stalled rsp side holds.
//  Synchronous reset loads the generator words and empties the output.
// ============================================================================
module rotate_add_prng_modulo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [rapm_pkg::WORD_W-1:0]  req_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rapm_pkg::WORD_W-1:0]  rsp_random_value
);

   localparam int W = rapm_pkg::WORD_W;
   localparam int R = rapm_pkg::REM_W;
   localparam int C = rapm_pkg::CNT_W;

   rapm_pkg::state_type     state_ff, state_in;
   logic [W-1:0]            high_ff, high_in;
   logic [W-1:0]            low_ff, low_in;
   logic [W-1:0]            t_ff, t_in;
   logic [W-1:0]            div_ff, div_in;
   logic [W-1:0]            dvd_ff, dvd_in;
   logic [C-1:0]            cnt_ff, cnt_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]            rsp_value_ff, rsp_value_in;
   logic [W-1:0]            round_high;
   rapm_pkg::cell_ctrl_type cell_ctrl;
   logic [R-1:0]            rem;
   logic [R-1:0]            dvs_bits;
   logic [R-1:0]            shift_bits;
   logic [R:0]              borrow;
   logic                    accept;

   assign req_stall        = (state_ff != rapm_pkg::ST_IDLE);
   assign accept           = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;
   assign round_high       = rapm_pkg::rotl(high_ff) + t_ff;

   assign dvs_bits   = {1'b0, div_ff};
   assign shift_bits = {rem[R-2:0], dvd_ff[W-1]};
   assign borrow[0]  = 1'b0;

   for (genvar i = 0; i < R; i++) begin : g_cell
      rapm_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .dvs_bit    (dvs_bits[i]),
         .shift_in   (shift_bits[i]),
         .borrow_in  (borrow[i]),
         .restore    (borrow[R]),
         .borrow_out (borrow[i+1]),
         .rem_bit    (rem[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      t_in         = t_ff;
      div_in       = div_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      cell_ctrl    = '0;
      case (state_ff)
         rapm_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (req_cmd == rapm_pkg::CMD_SEED) begin
                  zero_in  = 1'b1;
                  state_in = rapm_pkg::ST_SEED;
                  if (req_operand == '0) begin
                     high_in = rapm_pkg::ZERO_SEED_HIGH;
                     t_in    = rapm_pkg::ZERO_SEED_T;
                  end else begin
                     high_in = req_operand ^ rapm_pkg::SEED_XOR_MASK;
                     t_in    = req_operand;
                  end
               end else if (req_operand == '0) begin
                  zero_in  = 1'b1;
                  state_in = rapm_pkg::ST_DONE;
               end else begin
                  zero_in  = 1'b0;
                  high_in  = rapm_pkg::rotl(high_ff) + low_ff;
                  div_in   = req_operand;
                  state_in = rapm_pkg::ST_ADVANCE;
               end
            end
         end
         rapm_pkg::ST_SEED: begin
            high_in = round_high;
            t_in    = t_ff + round_high;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == C'(rapm_pkg::SEED_ROUNDS - 1)) begin
               low_in   = t_ff + round_high;
               state_in = rapm_pkg::ST_DONE;
            end
         end
         rapm_pkg::ST_ADVANCE: begin
            low_in         = low_ff + high_ff;
            dvd_in         = high_ff;
            cell_ctrl.load = 1'b1;
            state_in       = rapm_pkg::ST_DIVIDE;
         end
         rapm_pkg::ST_DIVIDE: begin
            cell_ctrl.step = 1'b1;
            dvd_in         = {dvd_ff[W-2:0], 1'b0};
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == C'(W - 1)) begin
               state_in = rapm_pkg::ST_DONE;
            end
         end
         rapm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = zero_ff ? '0 : rem[W-1:0];
               state_in     = rapm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rapm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rapm_pkg::ST_IDLE;
         high_ff      <= rapm_pkg::RESET_HIGH;
         low_ff       <= rapm_pkg::RESET_LOW;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      div_ff       <= div_in;
      dvd_ff       <= dvd_in;
      zero_ff      <= zero_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule
